/* rtl/irpc_pkg.sv */
// ----------------------------------------------------------------------------
// irpc_pkg: shared types and constants of the IR pulse capture/replay block
// Item kinds, host command codes, parse modes and the item/result records.
// ----------------------------------------------------------------------------
package irpc_pkg;

    localparam int DEFAULT_COUNT_BITS = 16;

    localparam int DUR_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int FUNC_W   = 2;
    localparam int PERIOD_W = 8;
    localparam int DUTY_W   = 9;

    // Item kinds.
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd2;

    // Host commands.
    localparam logic [BYTE_W-1:0] CMD_RESET  = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_PERIOD = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_TX     = 8'h03;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'h52;
    localparam logic [DUR_W-1:0]    END_PAIR     = 16'hFFFF;

    typedef enum logic [3:0] {
        PM_IDLE   = 4'b0001,
        PM_PARAM  = 4'b0010,
        PM_DATA_H = 4'b0100,
        PM_DATA_L = 4'b1000
    } t_parse_mode;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              pin_level;
        logic [BYTE_W-1:0] host_byte;
    } t_item;

    typedef struct packed {
        logic                sample_valid;
        logic [DUR_W-1:0]    sample_duration;
        logic                capture_ended;
        logic                carrier_on;
        logic [PERIOD_W-1:0] carrier_period;
        logic [DUTY_W-1:0]   carrier_duty_quarters;
        logic                byte_accepted;
        logic                exit_request;
    } t_result;

endpackage

/* rtl/irpc_if.sv */
// ----------------------------------------------------------------------------
// irpc_if: item channels of the IR pulse capture/replay block
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface irpc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       pin_level;
    logic [7:0] host_byte;

    modport source(output valid, func, pin_level, host_byte, input ready);
    modport sink(input valid, func, pin_level, host_byte, output ready);
endinterface

interface irpc_out_if;
    logic        valid;
    logic        ready;
    logic        sample_valid;
    logic [15:0] sample_duration;
    logic        capture_ended;
    logic        carrier_on;
    logic [7:0]  carrier_period;
    logic [8:0]  carrier_duty_quarters;
    logic        byte_accepted;
    logic        exit_request;

    modport source(output valid, sample_valid, sample_duration, capture_ended, carrier_on,
                   carrier_period, carrier_duty_quarters, byte_accepted, exit_request,
                   input ready);
    modport sink(input valid, sample_valid, sample_duration, capture_ended, carrier_on,
                 carrier_period, carrier_duty_quarters, byte_accepted, exit_request,
                 output ready);
endinterface

/* rtl/irpc_engine.sv */
// ----------------------------------------------------------------------------
// irpc_engine: capture counter, transmit sequencer and host byte parser
// Holds the capture, transmit and parser state and computes one result for each item it is given.
// ----------------------------------------------------------------------------
module irpc_engine #(
    parameter int COUNT_BITS = irpc_pkg::DEFAULT_COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  irpc_pkg::t_item  i_item,
    output irpc_pkg::t_result o_result
);
    import irpc_pkg::*;

    localparam int LW = (COUNT_BITS > DUR_W) ? COUNT_BITS : DUR_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LW-1:0] CNT_MAX_EXT = LW'(CNT_MAX);
    localparam logic [LW-1:0] DUR_MAX_EXT = LW'(END_PAIR);

    t_parse_mode           r_mode, n_mode;
    logic [COUNT_BITS-1:0] r_tick, n_tick;
    logic                  r_capture, n_capture;
    logic                  r_tx, n_tx;
    logic                  r_carrier, n_carrier;
    logic [DUR_W-1:0]      r_spare, n_spare;
    logic                  r_spare_full, n_spare_full;
    logic                  r_end_seen, n_end_seen;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic [BYTE_W-1:0]     r_pend_hi, n_pend_hi;
    logic                  r_rx_off, n_rx_off;

    // Segment counters run up to the maximum; a duration loads max - duration.
    function automatic logic [COUNT_BITS-1:0] load_for(input logic [DUR_W-1:0] dur);
        logic [LW-1:0] dur_ext;
        dur_ext = LW'(dur);
        if (dur_ext > CNT_MAX_EXT) begin
            return '0;
        end
        return COUNT_BITS'(CNT_MAX_EXT - dur_ext);
    endfunction

    logic [LW-1:0]    tick_ext;
    logic [DUR_W-1:0] pair;
    logic             at_max;
    logic             pair_end;

    assign tick_ext = LW'(r_tick);
    assign at_max   = (r_tick == CNT_MAX);
    assign pair     = {r_pend_hi, i_item.host_byte};
    assign pair_end = (pair == END_PAIR);

    always_comb begin
        n_mode       = r_mode;
        n_tick       = r_tick;
        n_capture    = r_capture;
        n_tx         = r_tx;
        n_carrier    = r_carrier;
        n_spare      = r_spare;
        n_spare_full = r_spare_full;
        n_end_seen   = r_end_seen;
        n_period     = r_period;
        n_pend_hi    = r_pend_hi;
        n_rx_off     = r_rx_off;

        o_result = '0;

        unique case (i_item.func)
            FUNC_TICK: begin
                if (r_tx) begin
                    if (at_max) begin
                        if (!r_spare_full || r_end_seen) begin
                            n_tx         = 1'b0;
                            n_carrier    = 1'b0;
                            n_spare_full = 1'b0;
                            n_rx_off     = 1'b0;
                            n_tick       = '0;
                        end else begin
                            n_carrier    = !r_carrier;
                            n_tick       = load_for(r_spare);
                            n_spare_full = 1'b0;
                        end
                    end else begin
                        n_tick = r_tick + COUNT_BITS'(1);
                    end
                end else if (r_capture) begin
                    if (at_max) begin
                        o_result.sample_valid    = 1'b1;
                        o_result.capture_ended   = 1'b1;
                        o_result.sample_duration = END_PAIR;
                        n_capture                = 1'b0;
                        n_tick                   = '0;
                    end else begin
                        n_tick = r_tick + COUNT_BITS'(1);
                    end
                end
            end
            FUNC_EDGE: begin
                if (!r_rx_off) begin
                    if (!r_capture) begin
                        if (!i_item.pin_level) begin
                            n_capture = 1'b1;
                            n_tick    = '0;
                        end
                    end else begin
                        o_result.sample_valid    = 1'b1;
                        o_result.sample_duration = (tick_ext > DUR_MAX_EXT) ? END_PAIR
                                                                            : DUR_W'(tick_ext);
                        n_tick                   = '0;
                    end
                end
            end
            FUNC_BYTE: begin
                o_result.byte_accepted = 1'b1;
                unique case (r_mode)
                    PM_IDLE: begin
                        if (i_item.host_byte == CMD_RESET) begin
                            n_mode       = PM_IDLE;
                            n_tick       = '0;
                            n_capture    = 1'b0;
                            n_tx         = 1'b0;
                            n_carrier    = 1'b0;
                            n_spare      = '0;
                            n_spare_full = 1'b0;
                            n_end_seen   = 1'b0;
                            n_pend_hi    = '0;
                            n_rx_off     = 1'b0;
                            o_result.exit_request = 1'b1;
                        end else if (i_item.host_byte == CMD_PERIOD) begin
                            n_mode = PM_PARAM;
                        end else if (i_item.host_byte == CMD_TX) begin
                            n_tx         = 1'b0;
                            n_carrier    = 1'b0;
                            n_spare_full = 1'b0;
                            n_end_seen   = 1'b0;
                            n_capture    = 1'b0;
                            n_tick       = '0;
                            n_rx_off     = 1'b1;
                            n_mode       = PM_DATA_H;
                        end
                    end
                    PM_PARAM: begin
                        n_period = i_item.host_byte;
                        n_mode   = PM_IDLE;
                    end
                    PM_DATA_H: begin
                        if (r_spare_full) begin
                            o_result.byte_accepted = 1'b0;
                        end else begin
                            n_pend_hi = i_item.host_byte;
                            n_mode    = PM_DATA_L;
                        end
                    end
                    PM_DATA_L: begin
                        // The end pair is buffered like any other and closes the data phase.
                        n_end_seen = r_end_seen || pair_end;
                        if (!r_tx) begin
                            n_capture    = 1'b0;
                            n_rx_off     = 1'b1;
                            n_tx         = 1'b1;
                            n_carrier    = 1'b1;
                            n_tick       = load_for(pair);
                            n_spare_full = 1'b0;
                        end else begin
                            n_spare      = pair;
                            n_spare_full = 1'b1;
                        end
                        n_mode = (r_end_seen || pair_end) ? PM_IDLE : PM_DATA_H;
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
            default: begin
                n_mode = r_mode;
            end
        endcase

        o_result.carrier_on            = n_carrier;
        o_result.carrier_period        = n_period;
        o_result.carrier_duty_quarters = {n_period, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= PM_IDLE;
            r_tick       <= '0;
            r_capture    <= 1'b0;
            r_tx         <= 1'b0;
            r_carrier    <= 1'b0;
            r_spare_full <= 1'b0;
            r_end_seen   <= 1'b0;
            r_period     <= PERIOD_RESET;
            r_rx_off     <= 1'b0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_tick       <= n_tick;
            r_capture    <= n_capture;
            r_tx         <= n_tx;
            r_carrier    <= n_carrier;
            r_spare_full <= n_spare_full;
            r_end_seen   <= n_end_seen;
            r_period     <= n_period;
            r_rx_off     <= n_rx_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_spare   <= n_spare;
            r_pend_hi <= n_pend_hi;
        end
    end

endmodule

/* rtl/ir_pulse_capture_replay.sv */
// ----------------------------------------------------------------------------
// ir_pulse_capture_replay: IR pulse-width capture and carrier replay
// Input register, processing engine and result register with handshakes.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_in (timer tick, IR pin edge, or host byte) and
// exactly one result item per input item leaves on o_out, in order. Both
// channels use valid/ready; an item moves at a clock edge with both high.
// An accepted item sits in the input register; when it moves on, the engine
// updates its state and loads the result register, which drives o_out.valid.
// One item per cycle is sustained while the receiver keeps o_out.ready high;
// back-pressure on o_out is the only limit.
// When the receiver holds o_out.ready low, the result register keeps its
// item and the input register still takes one more item; after that i_in.ready
// drops until the result is taken, so nothing is lost or repeated.
// A synchronous active-low reset empties both registers, stops capture and
// transmit, puts the parser in its idle mode and sets the carrier period to
// 82. No clearing pass is needed; the block takes items right after reset.
// ----------------------------------------------------------------------------
module ir_pulse_capture_replay #(
    parameter int COUNT_BITS = irpc_pkg::DEFAULT_COUNT_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    irpc_in_if.sink    i_in,
    irpc_out_if.source o_out
);
    import irpc_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;
    logic    in_fire;

    assign advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire   = i_in.valid && i_in.ready;

    irpc_engine #(
        .COUNT_BITS(COUNT_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_in),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= '{func: i_in.func, pin_level: i_in.pin_level, host_byte: i_in.host_byte};
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid                 = r_out_valid;
    assign o_out.sample_valid          = r_out.sample_valid;
    assign o_out.sample_duration       = r_out.sample_duration;
    assign o_out.capture_ended         = r_out.capture_ended;
    assign o_out.carrier_on            = r_out.carrier_on;
    assign o_out.carrier_period        = r_out.carrier_period;
    assign o_out.carrier_duty_quarters = r_out.carrier_duty_quarters;
    assign o_out.byte_accepted         = r_out.byte_accepted;
    assign o_out.exit_request          = r_out.exit_request;

endmodule

/* sim/ir_replay_ledger_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_replay_ledger_pkg: expected-result ledger for the IR capture/replay block
// Keeps its own copy of the capture, parser and transmit state. For every
// item taken by the block it works out the result item, queues it, and then
// checks the result items leaving the block against that queue, in order.
// ----------------------------------------------------------------------------
package ir_replay_ledger_pkg;
    import irpc_pkg::*;

    localparam int CNT_BITS = DEFAULT_COUNT_BITS;
    localparam logic [CNT_BITS-1:0] CNT_TOP = '1;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int REPORT_LIMIT = 10;

    class ir_replay_ledger;
        t_parse_mode         mode;
        logic [CNT_BITS-1:0] ticks;
        bit                  capturing;
        bit                  tx_active;
        bit                  carrier;
        bit                  spare_full;
        bit                  end_seen;
        bit                  rx_off;
        logic [DUR_W-1:0]    spare_dur;
        logic [BYTE_W-1:0]   pending_hi;
        logic [PERIOD_W-1:0] period;
        t_result             expected_results[$];
        int mismatches;
        int busy_items;
        int samples;
        int end_markers;
        int runs;
        int refused;
        int exits;

        function new();
            clear_state();
            period      = PERIOD_RESET;
            mismatches  = 0;
            busy_items  = 0;
            samples     = 0;
            end_markers = 0;
            runs        = 0;
            refused     = 0;
            exits       = 0;
        endfunction

        // Everything but the carrier period goes back to its reset value.
        function void clear_state();
            mode       = PM_IDLE;
            ticks      = '0;
            capturing  = 1'b0;
            tx_active  = 1'b0;
            carrier    = 1'b0;
            spare_full = 1'b0;
            end_seen   = 1'b0;
            rx_off     = 1'b0;
            spare_dur  = '0;
            pending_hi = '0;
        endfunction

        // The counter runs up to its top value, so a segment of d+1 ticks
        // is loaded with top-d; durations beyond the counter saturate.
        function logic [CNT_BITS-1:0] segment_load(logic [DUR_W-1:0] dur);
            if (CNT_BITS < DUR_W && dur > DUR_W'(CNT_TOP)) begin
                return '0;
            end
            return CNT_TOP - CNT_BITS'(dur);
        endfunction

        function t_result predict(t_item it);
            t_result          r;
            bit               idle_item;
            logic [DUR_W-1:0] pair;
            r = '0;
            idle_item = 1'b0;
            case (it.func)
                FUNC_TICK: begin
                    if (tx_active) begin
                        if (ticks == CNT_TOP) begin
                            if (!spare_full || end_seen) begin
                                tx_active  = 1'b0;
                                carrier    = 1'b0;
                                spare_full = 1'b0;
                                rx_off     = 1'b0;
                                ticks      = '0;
                            end else begin
                                carrier    = !carrier;
                                ticks      = segment_load(spare_dur);
                                spare_full = 1'b0;
                            end
                        end else begin
                            ticks++;
                        end
                    end else if (capturing) begin
                        if (ticks == CNT_TOP) begin
                            r.sample_valid    = 1'b1;
                            r.capture_ended   = 1'b1;
                            r.sample_duration = END_PAIR;
                            capturing         = 1'b0;
                            ticks             = '0;
                        end else begin
                            ticks++;
                        end
                    end else begin
                        idle_item = 1'b1;
                    end
                end
                FUNC_EDGE: begin
                    if (rx_off) begin
                        idle_item = 1'b1;
                    end else if (!capturing) begin
                        if (!it.pin_level) begin
                            capturing = 1'b1;
                            ticks     = '0;
                        end else begin
                            idle_item = 1'b1;
                        end
                    end else begin
                        r.sample_valid    = 1'b1;
                        r.sample_duration = (ticks > CNT_BITS'(END_PAIR)) ?
                                            END_PAIR : DUR_W'(ticks);
                        ticks = '0;
                    end
                end
                FUNC_BYTE: begin
                    r.byte_accepted = 1'b1;
                    case (mode)
                        PM_IDLE: begin
                            if (it.host_byte == CMD_RESET) begin
                                clear_state();
                                r.exit_request = 1'b1;
                            end else if (it.host_byte == CMD_PERIOD) begin
                                mode = PM_PARAM;
                            end else if (it.host_byte == CMD_TX) begin
                                tx_active  = 1'b0;
                                carrier    = 1'b0;
                                spare_full = 1'b0;
                                end_seen   = 1'b0;
                                capturing  = 1'b0;
                                ticks      = '0;
                                rx_off     = 1'b1;
                                mode       = PM_DATA_H;
                            end else begin
                                idle_item = 1'b1;
                            end
                        end
                        PM_PARAM: begin
                            period = it.host_byte;
                            mode   = PM_IDLE;
                        end
                        PM_DATA_H: begin
                            if (spare_full) begin
                                r.byte_accepted = 1'b0;
                            end else begin
                                pending_hi = it.host_byte;
                                mode       = PM_DATA_L;
                            end
                        end
                        default: begin
                            pair = {pending_hi, it.host_byte};
                            if (pair == END_PAIR) begin
                                end_seen = 1'b1;
                            end
                            if (!tx_active) begin
                                capturing  = 1'b0;
                                rx_off     = 1'b1;
                                tx_active  = 1'b1;
                                carrier    = 1'b1;
                                ticks      = segment_load(pair);
                                spare_full = 1'b0;
                                runs++;
                            end else begin
                                spare_dur  = pair;
                                spare_full = 1'b1;
                            end
                            mode = end_seen ? PM_IDLE : PM_DATA_H;
                        end
                    endcase
                end
                default: idle_item = 1'b1;
            endcase
            r.carrier_on            = carrier;
            r.carrier_period        = period;
            r.carrier_duty_quarters = {period, 1'b0};
            if (!idle_item) begin
                busy_items++;
            end
            if (r.sample_valid) begin
                samples++;
            end
            if (r.capture_ended) begin
                end_markers++;
            end
            if (it.func == FUNC_BYTE && !r.byte_accepted) begin
                refused++;
            end
            if (r.exit_request) begin
                exits++;
            end
            return r;
        endfunction

        function void note_item(t_item it);
            expected_results.push_back(predict(it));
        endfunction

        function string describe(t_result r);
            return $sformatf({"sample=%0d dur=%h end=%0d carrier=%0d period=%0d ",
                              "duty=%0d taken=%0d exit=%0d"},
                             r.sample_valid, r.sample_duration, r.capture_ended,
                             r.carrier_on, r.carrier_period, r.carrier_duty_quarters,
                             r.byte_accepted, r.exit_request);
        endfunction

        function void check_result(t_result got);
            t_result want;
            string   bad;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: result item with none expected: %s", describe(got));
                end
                return;
            end
            want = expected_results.pop_front();
            bad = "";
            if (got.sample_valid !== want.sample_valid) bad = {bad, " sample_valid"};
            if (got.sample_duration !== want.sample_duration) bad = {bad, " sample_duration"};
            if (got.capture_ended !== want.capture_ended) bad = {bad, " capture_ended"};
            if (got.carrier_on !== want.carrier_on) bad = {bad, " carrier_on"};
            if (got.carrier_period !== want.carrier_period) bad = {bad, " carrier_period"};
            if (got.carrier_duty_quarters !== want.carrier_duty_quarters) begin
                bad = {bad, " carrier_duty_quarters"};
            end
            if (got.byte_accepted !== want.byte_accepted) bad = {bad, " byte_accepted"};
            if (got.exit_request !== want.exit_request) bad = {bad, " exit_request"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: wrong field(s)%s at %0t", bad, $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the IR pulse capture/replay block
// Drives timer ticks, pin edges and host bytes through the input channel in
// random bursts while the result channel stalls on its own pattern. A short
// directed part covers the command set, the edge cases of capture and of
// the transmit buffer; random capture sessions, transmit sessions, period
// changes, resets and noise follow. Every result item is checked in order.
// ----------------------------------------------------------------------------
module tb;
    import irpc_pkg::*;
    import ir_replay_ledger_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;

    irpc_in_if  in_ch();
    irpc_out_if out_ch();

    ir_pulse_capture_replay dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    ir_replay_ledger ledger = new();
    int              burst_left;
    int              cycle_count;
    longint          items_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: run stopped after %0d cycles without finishing", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: ready follows a rotating mask that is redrawn now and then,
    // giving stretches of free flow, scattered stalls and long stalls.
    initial begin
        logic [15:0] stall_mask;
        int          hold;
        stall_mask = '1;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                hold = $urandom_range(32, 400);
                case ($urandom_range(0, 7))
                    0: stall_mask = '1;
                    1: stall_mask = 16'h0001 << $urandom_range(0, 15);
                    default: stall_mask = 16'($urandom | $urandom);
                endcase
            end
            hold--;
            out_ch.ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.sample_valid          = out_ch.sample_valid;
            got.sample_duration       = out_ch.sample_duration;
            got.capture_ended         = out_ch.capture_ended;
            got.carrier_on            = out_ch.carrier_on;
            got.carrier_period        = out_ch.carrier_period;
            got.carrier_duty_quarters = out_ch.carrier_duty_quarters;
            got.byte_accepted         = out_ch.byte_accepted;
            got.exit_request          = out_ch.exit_request;
            ledger.check_result(got);
        end
    end

    function automatic t_item make_item(logic [FUNC_W-1:0] f, logic lvl, logic [7:0] b);
        t_item it;
        it.func      = f;
        it.pin_level = lvl;
        it.host_byte = b;
        return it;
    endfunction

    // The sender works in bursts; a gap of idle cycles, sometimes none, opens each new burst.
    task automatic send_item(input t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 32);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.func      <= it.func;
        in_ch.pin_level <= it.pin_level;
        in_ch.host_byte <= it.host_byte;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        burst_left--;
        items_sent++;
        ledger.note_item(it);
    endtask

    task automatic send_tick();
        send_item(make_item(FUNC_TICK, 1'($urandom_range(0, 1)), 8'($urandom)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_tick();
    endtask

    task automatic send_edge(input logic lvl);
        send_item(make_item(FUNC_EDGE, lvl, 8'($urandom)));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(make_item(FUNC_BYTE, 1'($urandom_range(0, 1)), b));
    endtask

    // Holds the input idle until every result item has come back.
    task automatic pause_until_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    // Brings the parser back to command mode; the end pair closes data mode.
    task automatic return_to_idle();
        while (ledger.mode != PM_IDLE) begin
            case (ledger.mode)
                PM_PARAM: send_byte(8'($urandom));
                PM_DATA_H: begin
                    if (ledger.spare_full) begin
                        send_tick();
                    end else begin
                        send_byte(END_PAIR[15:8]);
                    end
                end
                default: send_byte(END_PAIR[7:0]);
            endcase
        end
    endtask

    initial begin
        int   directed_busy;
        int   n;
        logic level;

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= FUNC_TICK;
        in_ch.pin_level <= 1'b1;
        in_ch.host_byte <= '0;
        burst_left = 0;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unused item kind, then a rising edge that must not start a capture.
        send_item(make_item(FUNC_UNUSED, 1'b1, 8'hFF));
        send_edge(1'b1);
        send_edge(1'b0);
        send_ticks(3);
        send_edge(1'b1);
        send_edge(1'b0);
        send_byte(CMD_PERIOD);
        send_byte(8'h00);
        send_byte(CMD_PERIOD);
        send_byte(8'hFF);
        send_byte(8'hA5);

        // Transmit: one playing pair, one spare, a refused byte, an ignored edge.
        send_byte(CMD_TX);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h00);
        send_edge(1'b0);
        while (ledger.spare_full) send_tick();
        // End pair queued while playing, then a new transmit command stops the run.
        send_byte(END_PAIR[15:8]);
        send_byte(END_PAIR[7:0]);
        send_byte(CMD_TX);
        // A lone pair ends on the empty buffer and re-enables receive.
        send_byte(8'h00);
        send_byte(8'h00);
        while (ledger.tx_active) send_tick();
        send_edge(1'b0);
        // End pair starting a run, which the reset command then stops.
        send_byte(END_PAIR[15:8]);
        send_byte(END_PAIR[7:0]);
        send_ticks(4);
        send_byte(CMD_RESET);

        // A long pulse measured between a falling and a rising edge.
        send_edge(1'b0);
        send_ticks(300);
        send_edge(1'b1);
        send_ticks(20);
        send_byte(CMD_PERIOD);
        send_byte(PERIOD_RESET);
        pause_until_drained();

        directed_busy = ledger.busy_items;
        while (ledger.busy_items - directed_busy < RANDOM_ITEMS) begin
            n = $urandom_range(0, 99);
            if (n < 35) begin
                // Capture session with mostly alternating edges.
                return_to_idle();
                if (ledger.rx_off || $urandom_range(0, 3) == 0) begin
                    send_byte(CMD_RESET);
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_edge(1'b1);
                end
                level = 1'b0;
                send_edge(level);
                repeat ($urandom_range(2, 12)) begin
                    send_ticks(($urandom_range(0, 9) == 0) ? $urandom_range(41, 600)
                                                           : $urandom_range(0, 40));
                    level = ($urandom_range(0, 7) == 0) ? level : !level;
                    send_edge(level);
                end
            end else if (n < 70) begin
                // Transmit session with short segments.
                return_to_idle();
                send_byte(CMD_TX);
                repeat ($urandom_range(1, 6)) begin
                    while (ledger.spare_full) begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_byte(8'($urandom));
                        end else begin
                            send_tick();
                        end
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        send_edge(1'($urandom_range(0, 1)));
                    end
                    send_byte(($urandom_range(0, 7) == 0) ? 8'd1 : 8'd0);
                    if ($urandom_range(0, 3) == 0) begin
                        send_ticks($urandom_range(1, 5));
                    end
                    send_byte(8'(($urandom_range(0, 7) == 0) ? $urandom
                                                             : $urandom_range(0, 40)));
                    send_ticks($urandom_range(0, 50));
                end
                case ($urandom_range(0, 2))
                    0: begin
                        while (ledger.spare_full) send_tick();
                        if (ledger.tx_active) begin
                            send_byte(END_PAIR[15:8]);
                            send_byte(END_PAIR[7:0]);
                            if ($urandom_range(0, 1) == 0) begin
                                send_byte(CMD_TX);
                            end
                        end
                    end
                    1: while (ledger.tx_active) send_tick();
                    default: ;
                endcase
            end else if (n < 80) begin
                return_to_idle();
                send_byte(CMD_PERIOD);
                case ($urandom_range(0, 3))
                    0: send_byte(8'h00);
                    1: send_byte(8'hFF);
                    default: send_byte(8'($urandom));
                endcase
            end else if (n < 90) begin
                // Noise; high duration bytes stay small to keep segments short.
                repeat ($urandom_range(1, 8)) begin
                    send_item(make_item(FUNC_W'($urandom_range(0, FUNC_UNUSED)),
                                        1'($urandom_range(0, 1)),
                                        8'((ledger.mode == PM_DATA_H) ? $urandom_range(0, 1)
                                                                      : $urandom)));
                end
            end else if (n < 95) begin
                return_to_idle();
                send_byte(CMD_RESET);
            end else begin
                pause_until_drained();
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d durations (%0d timeout markers), %0d transmit runs,",
                 items_sent, ledger.samples, ledger.end_markers, ledger.runs);
        $display("%0d refused bytes and %0d reset commands.", ledger.refused, ledger.exits);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d bad result items, %0d missing", ledger.mismatches, ledger.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
